/* design/srwa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor registry package
// Shared types, widths and codes of the sensor registry with aging.
// ----------------------------------------------------------------------------
package srwa_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

    localparam int TIME_W   = 32;
    localparam int MAC_W    = 48;
    localparam int CNT_W    = 3;
    localparam int LEVEL_W  = 16;
    localparam int TEMP_W   = 16;
    localparam int CAT_W    = 8;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 3;
    localparam int TALLY_W  = 4;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 40;

    typedef enum logic
    {
        CMD_REPORT = 1'b0,
        CMD_SWEEP  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STAT_UPDATED = 2'd0,
        STAT_NEW     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_SWEEP   = 2'd3
    } status_t;

    localparam logic [CAT_W-1:0] CAT_ALERT = 8'd2;

    typedef struct packed
    {
        cmd_t                      cmd;
        logic [TIME_W-1:0]         now_time;
        logic [MAC_W-1:0]          sensor_mac;
        logic [CNT_W-1:0]          value_count;
        logic [LEVEL_W-1:0]        water_level;
        logic signed [TEMP_W-1:0]  temperature;
        logic [CAT_W-1:0]          category;
    } item_t;

    typedef struct packed
    {
        status_t              status;
        logic [INDEX_W-1:0]   slot_index;
        logic [LEVEL_W-1:0]   stored_level;
        logic [CAT_W-1:0]     stored_category;
        logic                 red_lamp;
        logic [TALLY_W-1:0]   expired_count;
        logic [TALLY_W-1:0]   active_total;
    } result_t;

    // One slot as it sits in the slot memory.
    typedef struct packed
    {
        logic [CAT_W-1:0]     cat;
        logic [TEMP_W-1:0]    temp;
        logic [LEVEL_W-1:0]   level;
        logic [TIME_W-1:0]    last_seen;
        logic [MAC_W-1:0]     key;
    } slot_word_t;

endpackage

/* design/sensor_registry_with_aging.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor registry with aging
// Keyed table of sensor slots with report updates and timeout sweeps.
// ----------------------------------------------------------------------------
//  channel   direction  signals                           word
//  s_*       in         s_tvalid s_tready s_tdata s_tuser one report or sweep
//  m_*       out        m_tvalid m_tready m_tdata m_tuser one result per item
//  cfg_*     in         cfg_valid cfg_ready cfg_data      timeout_ms register
//
// Each item walks the slot memory with one read per cycle; a written report
// then does a read-modify-write of the chosen slot. One item is in work at
// a time; the next is taken once the result has moved to the output
// register, which holds it while m_tready is low.
// Reset clears all slots, the active count, the lamp and sets the timeout to
// 30000 ms. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module sensor_registry_with_aging #(
    parameter int SLOTS = srwa_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_time, sensor_mac, value_count, water_level, temperature, category
    input  logic [srwa_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot_index, stored_level, stored_category, red_lamp, expired_count,
    // active_total
    output logic [srwa_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [srwa_pkg::STATUS_W-1:0]  m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srwa_pkg::TIME_W-1:0]    cfg_data
);

    logic [srwa_pkg::TIME_W-1:0] timeout_reg;
    logic                        out_valid_reg;
    srwa_pkg::result_t           out_reg;
    srwa_pkg::item_t             item;
    srwa_pkg::result_t           res;
    logic                        res_valid;
    logic                        res_ready;

    assign item.cmd         = srwa_pkg::cmd_t'(s_tuser);
    assign item.now_time    = s_tdata[31:0];
    assign item.sensor_mac  = s_tdata[79:32];
    assign item.value_count = s_tdata[82:80];
    assign item.water_level = s_tdata[98:83];
    assign item.temperature = s_tdata[114:99];
    assign item.category    = s_tdata[122:115];

    srwa_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .timeout_ms (timeout_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign cfg_ready = 1'b1;
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= srwa_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'b0000,
                       out_reg.active_total,
                       out_reg.expired_count,
                       out_reg.red_lamp,
                       out_reg.stored_category,
                       out_reg.stored_level,
                       out_reg.slot_index};

endmodule

/* design/srwa_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor registry engine
// Slot memory plus the sequencer that walks it for lookup, allocation,
// read-modify-write of a slot and the aging sweep.
// ----------------------------------------------------------------------------
module srwa_engine #(
    parameter int SLOTS = srwa_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  srwa_pkg::item_t              item,
    input  logic [srwa_pkg::TIME_W-1:0]  timeout_ms,
    output logic                         res_valid,
    input  logic                         res_ready,
    output srwa_pkg::result_t            res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] LAST_PTR = CW'(SLOTS);

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_MODIFY = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [IW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 hit_found_reg, hit_found_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    logic [IW-1:0]        target_reg, target_next;
    logic                 is_new_reg, is_new_next;
    logic [CW-1:0]        expired_reg, expired_next;
    logic [CW-1:0]        active_reg, active_next;
    logic                 lamp_reg, lamp_next;
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic [SLOTS-1:0]     written_reg, written_next;
    srwa_pkg::result_t    result_reg, result_next;
    srwa_pkg::item_t      item_reg;

    srwa_pkg::slot_word_t mem_array [SLOTS];
    srwa_pkg::slot_word_t rd_data_reg;
    logic [IW-1:0]        rd_addr;
    logic                 mem_we;
    srwa_pkg::slot_word_t mem_wdata;

    srwa_pkg::slot_word_t old_word;
    srwa_pkg::slot_word_t new_word;
    logic [srwa_pkg::TIME_W-1:0] age;
    logic                 slot_live;
    logic [CW-1:0]        active_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[target_reg] <= mem_wdata;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ptr_reg        <= '0;
            chk_vld_reg    <= 1'b0;
            chk_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            target_reg     <= '0;
            is_new_reg     <= 1'b0;
            expired_reg    <= '0;
            active_reg     <= '0;
            lamp_reg       <= 1'b0;
            valid_reg      <= '0;
            written_reg    <= '0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            target_reg     <= target_next;
            is_new_reg     <= is_new_next;
            expired_reg    <= expired_next;
            active_reg     <= active_next;
            lamp_reg       <= lamp_next;
            valid_reg      <= valid_next;
            written_reg    <= written_next;
            result_reg     <= result_next;
        end
    end

    // A slot that was never written reads as all zero.
    assign old_word   = written_reg[target_reg] ? rd_data_reg : '0;
    assign age        = item_reg.now_time - rd_data_reg.last_seen;
    assign slot_live  = valid_reg[chk_idx_reg];
    assign active_inc = active_reg + CW'(1);

    always_comb
    begin
        new_word           = old_word;
        new_word.key       = item_reg.sensor_mac;
        new_word.last_seen = item_reg.now_time;
        if (item_reg.value_count >= 3'd1)
        begin
            new_word.level = item_reg.water_level;
        end
        if (item_reg.value_count >= 3'd2)
        begin
            new_word.temp = item_reg.temperature;
        end
        if (item_reg.value_count >= 3'd3)
        begin
            new_word.cat = item_reg.category;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        target_next     = target_reg;
        is_new_next     = is_new_reg;
        expired_next    = expired_reg;
        active_next     = active_reg;
        lamp_next       = lamp_reg;
        valid_next      = valid_reg;
        written_next    = written_reg;
        result_next     = result_reg;
        rd_addr         = ptr_reg[IW-1:0];
        mem_we          = 1'b0;
        mem_wdata       = new_word;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ptr_next        = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    expired_next    = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle; the compare runs in the cycle after its read.
                if (ptr_reg < LAST_PTR)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = ptr_reg[IW-1:0];
                    ptr_next     = ptr_reg + CW'(1);
                end
                if (chk_vld_reg)
                begin
                    if (item_reg.cmd == srwa_pkg::CMD_SWEEP)
                    begin
                        if (slot_live && (age > timeout_ms))
                        begin
                            valid_next[chk_idx_reg] = 1'b0;
                            expired_next            = expired_reg + CW'(1);
                            if (active_reg != '0)
                            begin
                                active_next = active_reg - CW'(1);
                            end
                        end
                    end
                    else
                    begin
                        if (slot_live && !hit_found_reg &&
                            (rd_data_reg.key == item_reg.sensor_mac))
                        begin
                            hit_found_next = 1'b1;
                            hit_idx_next   = chk_idx_reg;
                        end
                        if (!slot_live && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                end
                if ((ptr_reg == LAST_PTR) && !chk_vld_reg)
                begin
                    result_next.status          = srwa_pkg::STAT_FULL;
                    result_next.slot_index      = '0;
                    result_next.stored_level    = '0;
                    result_next.stored_category = '0;
                    result_next.red_lamp        = lamp_reg;
                    result_next.expired_count   = '0;
                    result_next.active_total    = srwa_pkg::TALLY_W'(active_reg);
                    if (item_reg.cmd == srwa_pkg::CMD_SWEEP)
                    begin
                        result_next.status        = srwa_pkg::STAT_SWEEP;
                        result_next.expired_count = srwa_pkg::TALLY_W'(expired_reg);
                        state_next                = ST_DONE;
                    end
                    else if (hit_found_reg)
                    begin
                        target_next = hit_idx_reg;
                        is_new_next = 1'b0;
                        state_next  = ST_FETCH;
                    end
                    else if (free_found_reg)
                    begin
                        target_next = free_idx_reg;
                        is_new_next = 1'b1;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FETCH:
            begin
                rd_addr    = target_reg;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                mem_we                   = 1'b1;
                valid_next[target_reg]   = 1'b1;
                written_next[target_reg] = 1'b1;
                if (is_new_reg)
                begin
                    active_next = active_inc;
                end
                if (new_word.cat == srwa_pkg::CAT_ALERT)
                begin
                    lamp_next = 1'b1;
                end
                else if (new_word.cat < srwa_pkg::CAT_ALERT)
                begin
                    lamp_next = 1'b0;
                end
                result_next.status          = is_new_reg ? srwa_pkg::STAT_NEW
                                                         : srwa_pkg::STAT_UPDATED;
                result_next.slot_index      = srwa_pkg::INDEX_W'(target_reg);
                result_next.stored_level    = new_word.level;
                result_next.stored_category = new_word.cat;
                result_next.red_lamp        = lamp_next;
                result_next.expired_count   = '0;
                result_next.active_total    = srwa_pkg::TALLY_W'(active_next);
                state_next                  = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res        = result_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor registry testbench
// Drives report and sweep words into the registry and checks each result word
// against a predictor of the slot table. A directed opening covers extreme
// fields, the lamp rule, a full table, reuse of freed slots and timestamp
// wraparound. Random phases then run under several timeout settings, with
// idle gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

    localparam int          SLOTS      = srwa_pkg::SLOTS_DEFAULT;
    localparam int          KEY_POOL   = 12;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned SETTLE     = 20;
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned MAX_REPORT = 10;

    typedef struct
    {
        srwa_pkg::item_t it;
        int unsigned     gap;
    } queued_word_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [srwa_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [srwa_pkg::M_DATA_W-1:0]   m_tdata;
    logic [srwa_pkg::STATUS_W-1:0]   m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [srwa_pkg::TIME_W-1:0]     cfg_data  = '0;

    // Predicted slot table and register.
    logic                            ent_valid [SLOTS];
    logic [srwa_pkg::MAC_W-1:0]      ent_key   [SLOTS];
    logic [srwa_pkg::TIME_W-1:0]     ent_seen  [SLOTS];
    logic [srwa_pkg::LEVEL_W-1:0]    ent_level [SLOTS];
    logic [srwa_pkg::TEMP_W-1:0]     ent_temp  [SLOTS];
    logic [srwa_pkg::CAT_W-1:0]      ent_cat   [SLOTS];
    logic [srwa_pkg::TALLY_W-1:0]    live_count;
    logic                            lamp;
    logic [srwa_pkg::TIME_W-1:0]     timeout_cfg;

    queued_word_t                    word_q[$];
    srwa_pkg::result_t               awaited_results[$];
    srwa_pkg::item_t                 on_bus;
    int unsigned                     gap_left;
    int unsigned                     gap_max;
    int unsigned                     stall_left;
    int unsigned                     stall_max;
    int unsigned                     hold_left;
    int unsigned                     hold_requests;
    int unsigned                     hold_served;
    int unsigned                     idle_cycles;
    int unsigned                     mismatches;
    int unsigned                     n_items, n_new, n_upd, n_full, n_sweep, n_freed, n_cfg;
    logic [srwa_pkg::TIME_W-1:0]     clock_ms;
    logic [srwa_pkg::MAC_W-1:0]      key_pool [KEY_POOL];

    sensor_registry_with_aging #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic srwa_pkg::result_t table_update(input srwa_pkg::item_t it);
        srwa_pkg::result_t           r;
        logic [srwa_pkg::TIME_W-1:0] age;
        int                          hit;
        r = '0;
        hit = -1;
        n_items++;
        if (it.cmd == srwa_pkg::CMD_SWEEP)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                age = it.now_time - ent_seen[i];
                if (ent_valid[i] && age > timeout_cfg)
                begin
                    ent_valid[i] = 1'b0;
                    if (live_count > 0)
                        live_count--;
                    r.expired_count++;
                end
            end
            r.status = srwa_pkg::STAT_SWEEP;
            n_sweep++;
            n_freed += r.expired_count;
        end
        else
        begin
            r.status = srwa_pkg::STAT_UPDATED;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hit < 0 && ent_valid[i] && ent_key[i] == it.sensor_mac)
                    hit = i;
            end
            if (hit < 0)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (hit < 0 && !ent_valid[i])
                    begin
                        hit = i;
                        live_count++;
                        r.status = srwa_pkg::STAT_NEW;
                    end
                end
            end
            if (hit < 0)
            begin
                r.status = srwa_pkg::STAT_FULL;
                n_full++;
            end
            else
            begin
                ent_key[hit] = it.sensor_mac;
                ent_valid[hit] = 1'b1;
                if (it.value_count >= 1)
                    ent_level[hit] = it.water_level;
                if (it.value_count >= 2)
                    ent_temp[hit] = it.temperature;
                if (it.value_count >= 3)
                    ent_cat[hit] = it.category;
                ent_seen[hit] = it.now_time;
                // The lamp follows the category held in the slot, not the one sent.
                if (ent_cat[hit] == srwa_pkg::CAT_ALERT)
                    lamp = 1'b1;
                else if (ent_cat[hit] < srwa_pkg::CAT_ALERT)
                    lamp = 1'b0;
                r.slot_index = hit[srwa_pkg::INDEX_W-1:0];
                r.stored_level = ent_level[hit];
                r.stored_category = ent_cat[hit];
                if (r.status == srwa_pkg::STAT_NEW)
                    n_new++;
                else
                    n_upd++;
            end
        end
        r.red_lamp = lamp;
        r.active_total = live_count;
        return r;
    endfunction

    // Sender: each word waits out the gap drawn for the word before it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(), table_update(on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (word_q.size() > 0)
                begin
                    on_bus   <= word_q[0].it;
                    s_tdata  <= {5'b0, word_q[0].it.category, word_q[0].it.temperature,
                                 word_q[0].it.water_level, word_q[0].it.value_count,
                                 word_q[0].it.sensor_mac, word_q[0].it.now_time};
                    s_tuser  <= word_q[0].it.cmd;
                    gap_left <= word_q[0].gap;
                    s_tvalid <= 1'b1;
                    void'(word_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word, then stalls for a drawn number of cycles.
    always @(posedge clk)
    begin
        srwa_pkg::result_t exp_r;
        srwa_pkg::result_t got;
        int unsigned d;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = srwa_pkg::status_t'(m_tuser);
                got.slot_index = m_tdata[2:0];
                got.stored_level = m_tdata[18:3];
                got.stored_category = m_tdata[26:19];
                got.red_lamp = m_tdata[27];
                got.expired_count = m_tdata[31:28];
                got.active_total = m_tdata[35:32];
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("%0t: result word arrived with none expected", $time);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (got.status !== exp_r.status
                        || got.slot_index !== exp_r.slot_index
                        || got.stored_level !== exp_r.stored_level
                        || got.stored_category !== exp_r.stored_category
                        || got.red_lamp !== exp_r.red_lamp
                        || got.expired_count !== exp_r.expired_count
                        || got.active_total !== exp_r.active_total)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display({"%0t: expected status %0d slot %0d level %0d cat %0d ",
                                      "lamp %0d freed %0d active %0d, got %0d %0d %0d %0d ",
                                      "%0d %0d %0d"}, $time,
                                     exp_r.status, exp_r.slot_index, exp_r.stored_level,
                                     exp_r.stored_category, exp_r.red_lamp,
                                     exp_r.expired_count, exp_r.active_total,
                                     got.status, got.slot_index, got.stored_level,
                                     got.stored_category, got.red_lamp,
                                     got.expired_count, got.active_total);
                    end
                end
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_requests != hold_served)
            begin
                hold_served <= hold_requests;
                hold_left <= LONG_HOLD;
                m_tready <= 1'b0;
            end
            else if (m_tvalid && m_tready)
            begin
                d = $urandom_range(0, stall_max);
                stall_left <= d;
                m_tready <= (d == 0);
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_tready <= (stall_left == 1);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_item(input srwa_pkg::item_t it);
        queued_word_t w;
        w.it = it;
        w.gap = $urandom_range(0, gap_max);
        word_q.insert(word_q.size(), w);
    endtask

    task automatic push_report(input logic [31:0] t, input logic [47:0] mac, input int cnt,
                               input logic [15:0] lvl, input logic [15:0] tmp,
                               input logic [7:0] cat);
        srwa_pkg::item_t it;
        it.cmd = srwa_pkg::CMD_REPORT;
        it.now_time = t;
        it.sensor_mac = mac;
        it.value_count = cnt[srwa_pkg::CNT_W-1:0];
        it.water_level = lvl;
        it.temperature = tmp;
        it.category = cat;
        queue_item(it);
    endtask

    task automatic push_sweep(input logic [31:0] t);
        srwa_pkg::item_t it;
        it.cmd = srwa_pkg::CMD_SWEEP;
        it.now_time = t;
        it.sensor_mac = srwa_pkg::MAC_W'({$urandom, $urandom});
        it.value_count = srwa_pkg::CNT_W'($urandom);
        it.water_level = srwa_pkg::LEVEL_W'($urandom);
        it.temperature = srwa_pkg::TEMP_W'($urandom);
        it.category = srwa_pkg::CAT_W'($urandom);
        queue_item(it);
    endtask

    // Mostly a small set of sensors reporting over advancing time, so that the
    // table fills, refuses and ages out; a few fully random words as noise.
    task automatic push_random(input int n, input int unsigned step_max,
                               input int unsigned sweep_odds);
        srwa_pkg::item_t it;
        for (int k = 0; k < n; k++)
        begin
            if (k % 30 == 0)
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
            if ($urandom_range(0, 19) == 0)
            begin
                it.cmd = srwa_pkg::cmd_t'($urandom_range(0, 1));
                it.now_time = $urandom;
                it.sensor_mac = srwa_pkg::MAC_W'({$urandom, $urandom});
                it.value_count = srwa_pkg::CNT_W'($urandom);
                it.water_level = srwa_pkg::LEVEL_W'($urandom);
                it.temperature = srwa_pkg::TEMP_W'($urandom);
                it.category = srwa_pkg::CAT_W'($urandom);
                queue_item(it);
            end
            else
            begin
                clock_ms += $urandom_range(0, step_max);
                if ($urandom_range(0, sweep_odds - 1) == 0)
                    push_sweep(clock_ms);
                else
                    push_report(clock_ms, key_pool[$urandom_range(0, KEY_POOL - 1)],
                                $urandom_range(0, 7), 16'($urandom), 16'($urandom),
                                8'(($urandom_range(0, 7) == 0) ? $urandom
                                                               : $urandom_range(0, 2)));
            end
        end
    endtask

    // Checked away from the active edge, so that words just handed to the bus
    // are seen.
    task automatic wait_drained();
        while (word_q.size() > 0 || s_tvalid || awaited_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [srwa_pkg::TIME_W-1:0] v);
        @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        timeout_cfg = v;
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ent_valid[i] = 1'b0;
            ent_key[i] = '0;
            ent_seen[i] = '0;
            ent_level[i] = '0;
            ent_temp[i] = '0;
            ent_cat[i] = '0;
        end
        live_count = '0;
        lamp = 1'b0;
        timeout_cfg = srwa_pkg::TIMEOUT_RESET;
        gap_max = 19;
        stall_max = 19;
        hold_requests = 0;
        mismatches = 0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++)
            key_pool[i] = srwa_pkg::MAC_W'({$urandom, $urandom});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset timeout.
        push_sweep(32'd0);
        push_report(32'd0, 48'h0, 0, 16'h1234, 16'h1234, 8'd2);
        push_report(32'd10, 48'hFFFF_FFFF_FFFF, 7, 16'hFFFF, 16'h8000, 8'd2);
        push_report(32'd20, 48'hFFFF_FFFF_FFFF, 1, 16'h0000, 16'h0000, 8'd0);
        push_report(32'd30, 48'hFFFF_FFFF_FFFF, 3, 16'h0001, 16'h7FFF, 8'd255);
        push_report(32'd40, 48'h0, 3, 16'h00FF, 16'hFFFF, 8'd1);
        push_report(32'd50, 48'h0, 2, 16'hABCD, 16'h7FFF, 8'd2);
        // These stamps sit just below the wrap point, so later ages wrap around.
        for (int i = 1; i <= 6; i++)
            push_report(32'(32'hFFFF_FFF0 + i - 1), 48'(i), 3, 16'(i * 1000), 16'(-i),
                        8'd0);
        push_report(32'd55, 48'd7, 3, 16'd7, 16'd7, 8'd2);
        push_report(32'd60, 48'd3, 3, 16'd33, 16'd33, 8'd2);
        // Age equal to the timeout keeps a slot; one more millisecond frees it.
        push_sweep(32'd30030);
        push_sweep(32'd30031);
        push_report(32'd30040, 48'd8, 1, 16'd5, 16'd5, 8'd0);
        push_report(32'd30050, 48'd9, 0, 16'd9, 16'd9, 8'd9);
        wait_drained();

        set_timeout(32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_F000;
        push_random(130, 1000, 5);
        hold_requests++;
        wait_drained();

        set_timeout(32'd0);
        stall_max = 0;
        push_random(130, 3, 6);
        wait_drained();

        set_timeout($urandom_range(100, 3000));
        stall_max = 19;
        push_random(130, timeout_cfg / 3, 5);
        hold_requests++;
        wait_drained();

        set_timeout($urandom);
        stall_max = 4;
        push_random(130, timeout_cfg >> 2, 5);
        wait_drained();

        set_timeout(srwa_pkg::TIMEOUT_RESET);
        stall_max = 19;
        push_random(130, 8000, 5);
        wait_drained();

        $display("covered %0d words: %0d new slots, %0d updates, %0d refused on a full table",
                 n_items, n_new, n_upd, n_full);
        $display("%0d sweeps freed %0d slots across %0d timeout settings",
                 n_sweep, n_freed, n_cfg);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
